/* rtl/cpbf_pkg.sv */
// Shared types, constants and sequencer codes for the closest-pair search block.
// No dependencies; every other file in rtl/ except cpbf_ram imports this package.
`timescale 1ns / 1ps
package cpbf_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;
   localparam int ADDR_BITS  = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int DIST_BITS  = 2 * COORD_BITS + 1;
   localparam int BEST_BITS  = 2 * COORD_BITS + 3;
   localparam int POINT_BITS = 2 * COORD_BITS;

   // 4.0 in Q3.(2*COORD_BITS): above any reachable squared distance
   localparam logic [BEST_BITS-1:0] DIST_INIT = BEST_BITS'(4) << (2 * COORD_BITS);

   typedef struct packed {
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic                  final_point;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pair_x;
      logic [COORD_BITS-1:0] pair_y;
      logic [DIST_BITS-1:0]  min_dist_sq;
      logic                  second_member;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAP_I,
      ST_RD_J,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ADD,
      ST_CMP,
      ST_EMIT0,
      ST_EMIT1
   } state_type;

   typedef struct packed {
      logic sq_en;     // square the operand into the product register
      logic sum_load;  // load the product into the sum
      logic sum_add;   // add the product to the sum
   } sq_ctrl_type;

   typedef struct packed {
      sq_ctrl_type sq;
      logic        cap_i;       // hold point i from the read word
      logic        cap_j;       // hold point j and its differences to point i
      logic        sel_y;       // square dy instead of dx
      logic        compare;     // compare the pair distance with the best
      logic        clear_best;  // start a new search
      logic        zero_best;   // fewer than two points: report zeros
      logic        emit;        // a result word is on the port
      logic        second;      // second member of the pair
   } ctrl_type;

endpackage

/* rtl/cpbf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cpbf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cpbf_sq_unit.sv */
// Shared square-and-accumulate unit: one multiplier, a product register and a sum.
// Depends on cpbf_pkg.
`timescale 1ns / 1ps
module cpbf_sq_unit (
   input  logic                             clock,
   input  cpbf_pkg::sq_ctrl_type            ctrl,
   input  logic [cpbf_pkg::COORD_BITS-1:0]  operand,
   output logic [cpbf_pkg::DIST_BITS-1:0]   sum
);
   import cpbf_pkg::*;

   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;
   logic [DIST_BITS-1:0] sum_ff;
   logic [DIST_BITS-1:0] sum_in;

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.sq_en) begin
         prod_in = PROD_BITS'(operand) * PROD_BITS'(operand);
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.sum_load) begin
         sum_in = {1'b0, prod_ff};
      end else if (ctrl.sum_add) begin
         sum_in = sum_ff + {1'b0, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;

endmodule

/* rtl/cpbf_seq.sv */
// Sequencer: point counter, pair indexes and the state machine of the search.
// Depends on cpbf_pkg.
`timescale 1ns / 1ps
module cpbf_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           final_point,
   output logic                           busy,
   output cpbf_pkg::ctrl_type             ctrl,
   output logic                           wr_en,
   output logic [cpbf_pkg::ADDR_BITS-1:0] wr_addr,
   output logic [cpbf_pkg::ADDR_BITS-1:0] rd_addr
);
   import cpbf_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] n_ff, n_in;
   logic [ADDR_BITS-1:0] i_ff, i_in;
   logic [ADDR_BITS-1:0] j_ff, j_in;

   logic                accept;
   logic                room;
   logic [CNT_BITS-1:0] count_next;
   logic                more_j;
   logic                more_i;

   assign accept     = start && (state_ff == ST_IDLE);
   assign room       = (count_ff < CNT_BITS'(MAX_POINTS));
   assign count_next = room ? count_ff + CNT_BITS'(1) : count_ff;
   assign more_j     = (CNT_BITS'(j_ff) + CNT_BITS'(1)) < n_ff;
   assign more_i     = (CNT_BITS'(i_ff) + CNT_BITS'(2)) < n_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && final_point) begin
               state_in = (count_next < CNT_BITS'(2)) ? ST_EMIT0 : ST_CAP_I;
            end
         end
         ST_CAP_I: state_in = ST_RD_J;
         ST_RD_J:  state_in = ST_SQ_X;
         ST_SQ_X:  state_in = ST_SQ_Y;
         ST_SQ_Y:  state_in = ST_ADD;
         ST_ADD:   state_in = ST_CMP;
         ST_CMP: begin
            if (more_j) begin
               state_in = ST_RD_J;
            end else if (more_i) begin
               state_in = ST_CAP_I;
            end else begin
               state_in = ST_EMIT0;
            end
         end
         ST_EMIT0: state_in = ST_EMIT1;
         ST_EMIT1: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl    = '0;
      wr_en   = 1'b0;
      rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            wr_en   = accept && room;
            rd_addr = '0;
            if (accept && final_point) begin
               ctrl.zero_best  = (count_next < CNT_BITS'(2));
               ctrl.clear_best = !(count_next < CNT_BITS'(2));
            end
         end
         ST_CAP_I: begin
            ctrl.cap_i = 1'b1;
            rd_addr    = i_ff + ADDR_BITS'(1);
         end
         ST_RD_J: ctrl.cap_j = 1'b1;
         ST_SQ_X: ctrl.sq.sq_en = 1'b1;
         ST_SQ_Y: begin
            ctrl.sq.sq_en    = 1'b1;
            ctrl.sq.sum_load = 1'b1;
            ctrl.sel_y       = 1'b1;
         end
         ST_ADD: ctrl.sq.sum_add = 1'b1;
         ST_CMP: begin
            ctrl.compare = 1'b1;
            rd_addr      = more_j ? j_ff + ADDR_BITS'(1) : i_ff + ADDR_BITS'(1);
         end
         ST_EMIT0: ctrl.emit = 1'b1;
         ST_EMIT1: begin
            ctrl.emit   = 1'b1;
            ctrl.second = 1'b1;
         end
         default: ctrl = '0;
      endcase
   end

   // counters and indexes
   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = final_point ? '0 : count_next;
               n_in     = count_next;
               i_in     = '0;
            end
         end
         ST_CAP_I: j_in = i_ff + ADDR_BITS'(1);
         ST_CMP: begin
            if (more_j) begin
               j_in = j_ff + ADDR_BITS'(1);
            end else if (more_i) begin
               i_in = i_ff + ADDR_BITS'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
   end

   assign busy    = (state_ff != ST_IDLE);
   assign wr_addr = count_ff[ADDR_BITS-1:0];

endmodule

/* rtl/closest_pair_brute_force.sv */
// Top level of the brute-force closest-pair search: point store, datapath, outputs.
// Depends on cpbf_pkg, cpbf_ram, cpbf_sq_unit and cpbf_seq.
`timescale 1ns / 1ps
// Usage: present one point per word on req_data with start high; a word is taken
// at a clock edge where start is high and busy is low. Points load one per cycle
// into a 1024-entry store; points beyond the store's size are dropped. The word
// with final_point set closes the set and starts the search; busy then stays high
// until both results are out. The search walks every pair (i, j), i < j, in index
// order through one shared square-and-accumulate unit: one store read per outer
// index, then per pair the steps read, dx squared, dy squared, add and compare;
// the two result words follow. With fewer than two points the two zero results
// follow at once. Each result word sits on rsp_data for exactly one cycle with
// rsp_valid high, first member then second member; the receiver cannot stall the
// block, so it must take every word as it comes.
module closest_pair_brute_force (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cpbf_pkg::req_type req_data,
   output logic              rsp_valid,
   output cpbf_pkg::rsp_type rsp_data
);
   import cpbf_pkg::*;

   ctrl_type              ctrl;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [POINT_BITS-1:0] rd_data;
   logic [COORD_BITS-1:0] rd_x, rd_y;
   logic [COORD_BITS-1:0] operand;
   logic [DIST_BITS-1:0]  sum;

   // held points and their differences
   logic [COORD_BITS-1:0] pi_x_ff, pi_y_ff, pi_x_in, pi_y_in;
   logic [COORD_BITS-1:0] pj_x_ff, pj_y_ff, pj_x_in, pj_y_in;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;

   // best pair so far
   logic [BEST_BITS-1:0]  best_ff, best_in;
   logic [COORD_BITS-1:0] b0_x_ff, b0_y_ff, b0_x_in, b0_y_in;
   logic [COORD_BITS-1:0] b1_x_ff, b1_y_ff, b1_x_in, b1_y_in;

   cpbf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .final_point (req_data.final_point),
      .busy        (busy),
      .ctrl        (ctrl),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr)
   );

   cpbf_ram #(
      .WIDTH (POINT_BITS),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.point_x, req_data.point_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[POINT_BITS-1:COORD_BITS];
   assign rd_y = rd_data[COORD_BITS-1:0];

   // square dx first, then dy
   assign operand = ctrl.sel_y ? dy_ff : dx_ff;

   cpbf_sq_unit u_sq (
      .clock   (clock),
      .ctrl    (ctrl.sq),
      .operand (operand),
      .sum     (sum)
   );

   // capture point i at the head of each outer pass
   always_comb begin
      pi_x_in = pi_x_ff;
      pi_y_in = pi_y_ff;
      if (ctrl.cap_i) begin
         pi_x_in = rd_x;
         pi_y_in = rd_y;
      end
   end

   // capture point j and the absolute differences to point i
   always_comb begin
      pj_x_in = pj_x_ff;
      pj_y_in = pj_y_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      if (ctrl.cap_j) begin
         pj_x_in = rd_x;
         pj_y_in = rd_y;
         dx_in   = (rd_x >= pi_x_ff) ? rd_x - pi_x_ff : pi_x_ff - rd_x;
         dy_in   = (rd_y >= pi_y_ff) ? rd_y - pi_y_ff : pi_y_ff - rd_y;
      end
   end

   // keep the first strictly smaller pair; ties leave the earlier one
   always_comb begin
      best_in = best_ff;
      b0_x_in = b0_x_ff;
      b0_y_in = b0_y_ff;
      b1_x_in = b1_x_ff;
      b1_y_in = b1_y_ff;
      if (ctrl.zero_best) begin
         best_in = '0;
         b0_x_in = '0;
         b0_y_in = '0;
         b1_x_in = '0;
         b1_y_in = '0;
      end else if (ctrl.clear_best) begin
         best_in = DIST_INIT;
      end else if (ctrl.compare && ({2'b00, sum} < best_ff)) begin
         best_in = {2'b00, sum};
         b0_x_in = pi_x_ff;
         b0_y_in = pi_y_ff;
         b1_x_in = pj_x_ff;
         b1_y_in = pj_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      pi_x_ff <= pi_x_in;
      pi_y_ff <= pi_y_in;
      pj_x_ff <= pj_x_in;
      pj_y_ff <= pj_y_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      best_ff <= best_in;
      b0_x_ff <= b0_x_in;
      b0_y_ff <= b0_y_in;
      b1_x_ff <= b1_x_in;
      b1_y_ff <= b1_y_in;
   end

   // drive one result word per emit cycle
   assign rsp_valid              = ctrl.emit;
   assign rsp_data.pair_x        = ctrl.second ? b1_x_ff : b0_x_ff;
   assign rsp_data.pair_y        = ctrl.second ? b1_y_ff : b0_y_ff;
   assign rsp_data.min_dist_sq   = best_ff[DIST_BITS-1:0];
   assign rsp_data.second_member = ctrl.second;

endmodule

/* bench/testbench.sv */
// Self-checking bench for closest_pair_brute_force: point sets, pair search, result words.
// Depends on cpbf_pkg and the closest_pair_brute_force RTL.
`timescale 1ns / 1ps
module testbench;
   import cpbf_pkg::*;

   // Longest search, for a full store: one read per outer index plus the steps of each pair.
   localparam int PAIR_CYCLES  = (MAX_POINTS - 1) + 5 * MAX_POINTS * (MAX_POINTS - 1) / 2;
   localparam int STALL_LIMIT  = 3 * PAIR_CYCLES + 1000;
   localparam int RANDOM_ITEMS = 360;
   localparam int TAIL_ITEMS   = 150;   // last stretch of the random part runs without gaps
   localparam int SETTLE       = 20;

   typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_EDGE} spread_type;

   // Reference copy of the point store; predicts the pair words that each marked point causes.
   class pair_scoreboard;
      logic [POINT_BITS-1:0] points [MAX_POINTS];
      int unsigned           held;
      rsp_type               pair_q [$];
      int unsigned           mismatches;

      function new();
         held       = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return pair_q.size();
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
         mismatches++;
      endtask

      // Store the accepted point; on the mark, search every pair and queue both members.
      function void note_point(req_type w);
         logic [BEST_BITS-1:0]  best;
         logic [DIST_BITS-1:0]  d;
         logic [COORD_BITS-1:0] xa, ya, xb, yb, dx, dy;
         int                    first_idx, second_idx;
         rsp_type               r;
         if (held < MAX_POINTS) begin
            points[held] = {w.point_x, w.point_y};
            held++;
         end
         if (!w.final_point) return;
         best       = DIST_INIT;
         first_idx  = 0;
         second_idx = 0;
         for (int i = 0; i + 1 < held; i++) begin
            {xa, ya} = points[i];
            for (int j = i + 1; j < held; j++) begin
               {xb, yb} = points[j];
               dx = (xa >= xb) ? xa - xb : xb - xa;
               dy = (ya >= yb) ? ya - yb : yb - ya;
               d  = DIST_BITS'(dx) * DIST_BITS'(dx) + DIST_BITS'(dy) * DIST_BITS'(dy);
               // strict compare: the first pair in index order wins a tie
               if (BEST_BITS'(d) < best) begin
                  best       = BEST_BITS'(d);
                  first_idx  = i;
                  second_idx = j;
               end
            end
         end
         for (int k = 0; k < 2; k++) begin
            if (held < 2) begin
               r.pair_x      = '0;
               r.pair_y      = '0;
               r.min_dist_sq = '0;
            end else begin
               {r.pair_x, r.pair_y} = points[(k == 0) ? first_idx : second_idx];
               r.min_dist_sq        = best[DIST_BITS-1:0];
            end
            r.second_member = (k == 1);
            pair_q = {pair_q, r};
         end
         held = 0;
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (pair_q.size() == 0) begin
            report_mismatch("unexpected result word", 64'(got.min_dist_sq), 64'd0);
            return;
         end
         want = pair_q.pop_front();
         if (got.pair_x !== want.pair_x)
            report_mismatch("pair_x", 64'(got.pair_x), 64'(want.pair_x));
         if (got.pair_y !== want.pair_y)
            report_mismatch("pair_y", 64'(got.pair_y), 64'(want.pair_y));
         if (got.min_dist_sq !== want.min_dist_sq)
            report_mismatch("min_dist_sq", 64'(got.min_dist_sq), 64'(want.min_dist_sq));
         if (got.second_member !== want.second_member)
            report_mismatch("second_member", 64'(got.second_member),
                            64'(want.second_member));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   pair_scoreboard board = new();
   int             quiet_cycles = 0;

   closest_pair_brute_force dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Check every result word as it passes; the block cannot be held off, so take each one.
   // Count cycles in which no word moves in either direction for the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid)
            board.check_result(rsp_data);
         if ((start && !busy) || rsp_valid)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Kill a hung run: the limit covers a full-store search several times over.
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic req_type make_word(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                         logic last);
      req_type w;
      w.point_x     = x;
      w.point_y     = y;
      w.final_point = last;
      return w;
   endfunction

   // Draw one coordinate: anywhere, near an anchor (forces duplicates and ties), or at an edge.
   function automatic logic [COORD_BITS-1:0] pick_coord(spread_type spread,
                                                        logic [COORD_BITS-1:0] anchor);
      case (spread)
         SPREAD_FULL:    return COORD_BITS'($urandom);
         SPREAD_CLUSTER: return anchor + COORD_BITS'($urandom_range(0, 3));
         default: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return COORD_BITS'($urandom);
            endcase
         end
      endcase
   endfunction

   // Present one word and hold it until the block takes it; leave start high on return.
   task automatic send_word(req_type w);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      board.note_point(w);
   endtask

   // Drop start for a burst of idle cycles.
   task automatic idle_for(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and hold until every predicted word has arrived.
   task automatic hold_off();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Send a set of points, the last one marked; gaps land before any word, busy or not.
   task automatic send_set(int count, spread_type spread, bit gaps);
      logic [COORD_BITS-1:0] anchor_x, anchor_y;
      anchor_x = COORD_BITS'($urandom);
      anchor_y = COORD_BITS'($urandom);
      for (int k = 0; k < count; k++) begin
         if (gaps && $urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 5));
         send_word(make_word(pick_coord(spread, anchor_x), pick_coord(spread, anchor_y),
                             k == count - 1));
      end
   endtask

   initial begin
      int         sent;
      int         sets;
      int         size;
      int         pick;
      spread_type spread;
      bit         gaps;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone marked point gives two zero words
      send_word(make_word('1, '1, 1'b1));
      // opposite corners: largest reachable distance
      send_word(make_word('0, '0, 1'b0));
      send_word(make_word('1, '1, 1'b1));
      // anti-diagonal corners
      send_word(make_word('1, '0, 1'b0));
      send_word(make_word('0, '1, 1'b1));
      // duplicate points: zero distance
      send_word(make_word(16'h1234, 16'h5678, 1'b0));
      send_word(make_word(16'h1234, 16'h5678, 1'b1));
      // equal spacing: the tie goes to the first pair
      send_word(make_word(16'd10, 16'd10, 1'b0));
      send_word(make_word(16'd110, 16'd10, 1'b0));
      send_word(make_word(16'd210, 16'd10, 1'b1));
      // closest pair found late in index order
      send_word(make_word(16'd0, 16'd0, 1'b0));
      send_word(make_word(16'd40000, 16'd40000, 1'b0));
      send_word(make_word(16'd40001, 16'd40003, 1'b1));
      // alternating bit patterns on both axes
      send_word(make_word(16'hAAAA, 16'h5555, 1'b0));
      send_word(make_word(16'h5555, 16'hAAAA, 1'b1));
      hold_off();

      // Fill the store and overrun it: the last three plain words and the marked word drop,
      // and the search still runs over the stored points.
      send_set(MAX_POINTS + 4, SPREAD_FULL, 1'b1);
      hold_off();

      // Random sets, mostly small; drain the block now and then.
      sent = 0;
      sets = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            size = 1;
         else if (pick < 80)
            size = $urandom_range(2, 8);
         else if (pick < 97)
            size = $urandom_range(9, 24);
         else
            size = $urandom_range(25, 48);
         case ($urandom_range(0, 2))
            0:       spread = SPREAD_FULL;
            1:       spread = SPREAD_CLUSTER;
            default: spread = SPREAD_EDGE;
         endcase
         gaps = (sent < RANDOM_ITEMS - TAIL_ITEMS) && ($urandom_range(0, 9) < 7);
         send_set(size, spread, gaps);
         sent += size;
         sets++;
         if (sets % 40 == 0)
            hold_off();
      end

      // Drain, then let the block settle before the verdict.
      hold_off();
      repeat (SETTLE) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
